>>> rtl/ccrn_pkg.sv
// Shared types, constants and the 2^(2^-(i+1)) table for the response normalizer.
package ccrn_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 36;
	localparam int BASE_W   = 60;
	localparam int OFS_W    = 4;
	localparam int HALF_W   = 3;

	localparam logic [15:0] BIAS_K_RST        = 16'd512;
	localparam logic [23:0] SCALE_ALPHA_RST   = 24'd1678;
	localparam logic [15:0] EXPONENT_BETA_RST = 16'd12288;
	localparam logic [3:0]  WINDOW_SIZE_RST   = 4'd5;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef enum logic [1:0] {
		CFG_BIAS_K,
		CFG_SCALE_ALPHA,
		CFG_EXPONENT_BETA,
		CFG_WINDOW_SIZE
	} ccrn_cfg_idx_t;

	typedef struct packed {
		logic [15:0] bias_k;
		logic [23:0] scale_alpha;
		logic [15:0] exponent_beta;
	} ccrn_cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       zero_divisor;
		logic                       saturated;
	} ccrn_result_t;

	typedef logic [15:0][31:0] exp_table_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r = '0;
		rem = v;
		for (int s = 31; s >= 0; s--) begin
			b = 64'd1 << (2 * s);
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// Entry i is 2^(2^-(i+1)) in Q2.30, by repeated square roots from 2.
	function automatic exp_table_t build_exp_table();
		exp_table_t t;
		logic [63:0] c;
		c = 64'd2 << 30;
		for (int i = 0; i < 16; i++) begin
			c = isqrt64(c << 30);
			t[i] = c[31:0];
		end
		return t;
	endfunction

	localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

>>> rtl/ccrn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccrn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/ccrn_power.sv
// Iterative unit: denominator base, log2, power, exp2 and division of one sample.
module ccrn_power (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  ccrn_pkg::ccrn_cfg_t                   cfg,
	input  logic [ccrn_pkg::SUM_W-1:0]            sum,
	input  logic signed [ccrn_pkg::SAMPLE_W-1:0]  x,
	output logic                                  done,
	output ccrn_pkg::ccrn_result_t                result
);
	import ccrn_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE,
		P_MUL_LO,
		P_MUL_HI,
		P_ADD,
		P_NORM,
		P_LOG_MUL,
		P_LOG_ADJ,
		P_BETA,
		P_EXP_MUL,
		P_EXP_ADJ,
		P_DIV_SET,
		P_DIV_CHK,
		P_DIV,
		P_FIN
	} state_t;

	state_t              state_q;
	logic                done_q;
	ccrn_result_t        result_q;
	logic                neg_q;
	logic [15:0]         mag_q;
	logic [SUM_W-1:0]    sum_q;
	logic [63:0]         prod_q;
	logic [BASE_W-1:0]   base_q;
	logic [5:0]          p_q;
	logic                base_zero_q;
	logic [30:0]         m_q;
	logic [15:0]         frac_q;
	logic [4:0]          cnt_q;
	logic signed [25:0]  e16_q;
	logic [61:0]         num_q;
	logic [62:0]         den_q;
	logic [78:0]         dsh_q;
	logic [61:0]         rem_q;
	logic [16:0]         quo_q;
	logic                ovf_q;

	logic [17:0]         amul_op;
	logic [41:0]         amul;
	logic [31:0]         lop;
	logic [62:0]         lmul;
	logic [31:0]         sq_top;
	logic [6:0]          pexp;
	logic signed [22:0]  l16;
	logic signed [39:0]  beta_prod;
	logic signed [9:0]   ip;
	logic signed [10:0]  tsh;
	logic signed [10:0]  ntsh;
	logic [31:0]         factor;
	logic                ovf_cmp;
	logic                div_ge;
	logic [16:0]         mag_in;
	logic signed [15:0]  fin_val;
	logic                fin_sat;

	assign amul_op = (state_q == P_MUL_LO) ? sum_q[17:0] : sum_q[35:18];
	assign amul    = cfg.scale_alpha * amul_op;

	assign factor = e16_q[4'd15 - cnt_q[3:0]] ? EXP_TABLE[cnt_q[3:0]] : {1'b0, ONE_Q30};
	assign lop    = (state_q == P_EXP_MUL) ? factor : {1'b0, m_q};
	assign lmul   = m_q * lop;
	assign sq_top = prod_q[61:30];

	assign pexp      = {1'b0, p_q} - 7'd40;
	assign l16       = base_zero_q ? 23'sd0 : $signed({pexp, frac_q});
	assign beta_prod = $signed({1'b0, cfg.exponent_beta}) * l16;

	assign ip   = e16_q[25:16];
	assign tsh  = 11'sd30 - {ip[9], ip};
	assign ntsh = -tsh;

	assign ovf_cmp = {18'd0, num_q} >= {den_q, 17'd0};
	assign div_ge  = {17'd0, rem_q} >= dsh_q;

	assign mag_in = x[SAMPLE_W-1] ? 17'd0 - {x[SAMPLE_W-1], x} : {1'b0, x};

	always_comb begin
		fin_sat = 1'b0;
		fin_val = '0;
		if (ovf_q) begin
			fin_sat = 1'b1;
			fin_val = neg_q ? -16'sd32768 : 16'sd32767;
		end else if (neg_q) begin
			if (quo_q > 17'd32768) begin
				fin_sat = 1'b1;
				fin_val = -16'sd32768;
			end else begin
				fin_val = $signed(16'(17'd0 - quo_q));
			end
		end else begin
			if (quo_q > 17'd32767) begin
				fin_sat = 1'b1;
				fin_val = 16'sd32767;
			end else begin
				fin_val = $signed(quo_q[15:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						sum_q   <= sum;
						neg_q   <= x[SAMPLE_W-1];
						mag_q   <= mag_in[15:0];
						state_q <= P_MUL_LO;
					end
				end
				P_MUL_LO: begin
					prod_q  <= 64'(amul);
					base_q  <= BASE_W'({cfg.bias_k, 32'd0});
					state_q <= P_MUL_HI;
				end
				P_MUL_HI: begin
					base_q  <= base_q + BASE_W'(prod_q[41:0]);
					prod_q  <= 64'(amul);
					state_q <= P_ADD;
				end
				P_ADD: begin
					base_q      <= base_q + {prod_q[41:0], 18'd0};
					p_q         <= 6'(BASE_W - 1);
					base_zero_q <= 1'b0;
					frac_q      <= '0;
					state_q     <= P_NORM;
				end
				P_NORM: begin
					if (base_q == '0) begin
						base_zero_q <= 1'b1;
						if (cfg.exponent_beta != '0) begin
							result_q <= '{value: '0, zero_divisor: 1'b1, saturated: 1'b0};
							done_q   <= 1'b1;
							state_q  <= P_IDLE;
						end else begin
							state_q <= P_BETA;
						end
					end else if (base_q[BASE_W-1 -: 8] == '0) begin
						base_q <= base_q << 8;
						p_q    <= p_q - 6'd8;
					end else if (!base_q[BASE_W-1]) begin
						base_q <= base_q << 1;
						p_q    <= p_q - 6'd1;
					end else begin
						m_q     <= base_q[BASE_W-1 -: 31];
						cnt_q   <= '0;
						state_q <= P_LOG_MUL;
					end
				end
				P_LOG_MUL: begin
					prod_q  <= 64'(lmul);
					state_q <= P_LOG_ADJ;
				end
				P_LOG_ADJ: begin
					m_q    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
					frac_q <= {frac_q[14:0], sq_top[31]};
					if (cnt_q[3:0] == 4'd15) begin
						state_q <= P_BETA;
					end else begin
						cnt_q   <= cnt_q + 5'd1;
						state_q <= P_LOG_MUL;
					end
				end
				P_BETA: begin
					e16_q   <= beta_prod[39:14];
					m_q     <= ONE_Q30;
					cnt_q   <= '0;
					state_q <= P_EXP_MUL;
				end
				P_EXP_MUL: begin
					prod_q  <= 64'(lmul);
					state_q <= P_EXP_ADJ;
				end
				P_EXP_ADJ: begin
					m_q <= prod_q[60:30];
					if (cnt_q[3:0] == 4'd15) begin
						state_q <= P_DIV_SET;
					end else begin
						cnt_q   <= cnt_q + 5'd1;
						state_q <= P_EXP_MUL;
					end
				end
				P_DIV_SET: begin
					quo_q <= '0;
					ovf_q <= 1'b0;
					if (mag_q == '0 || tsh <= -11'sd33) begin
						state_q <= P_FIN;
					end else if (tsh >= 11'sd47) begin
						ovf_q   <= 1'b1;
						state_q <= P_FIN;
					end else if (tsh >= 11'sd0) begin
						num_q   <= 62'(mag_q) << tsh[5:0];
						den_q   <= 63'(m_q);
						state_q <= P_DIV_CHK;
					end else begin
						num_q   <= 62'(mag_q);
						den_q   <= 63'(m_q) << ntsh[5:0];
						state_q <= P_DIV_CHK;
					end
				end
				P_DIV_CHK: begin
					if (ovf_cmp) begin
						ovf_q   <= 1'b1;
						state_q <= P_FIN;
					end else begin
						rem_q   <= num_q;
						dsh_q   <= {den_q, 16'd0};
						cnt_q   <= 5'd16;
						state_q <= P_DIV;
					end
				end
				P_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - dsh_q[61:0];
					end
					quo_q <= {quo_q[15:0], div_ge};
					dsh_q <= dsh_q >> 1;
					if (cnt_q == '0) begin
						state_q <= P_FIN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				P_FIN: begin
					result_q <= '{value: fin_val, zero_divisor: 1'b0, saturated: fin_sat};
					done_q   <= 1'b1;
					state_q  <= P_IDLE;
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/cross_channel_response_normalizer.sv
// Top level: sample window RAM, window sum sequencer and result register.
//
//  port group   direction  handshake            payload
//  cfg          in         cfg_wr_en            cfg_index, cfg_wdata
//  in           in         in_valid / in_stall  sample, last_channel
//  out          out        out_valid / out_stall value, zero_divisor, saturated, last
//
// An input beat that emits nothing leaves the block idle. Every emitted result
// passes through setup, then a RAM read, square and accumulate step per window
// tap (up to 2*half+1 taps), then the power unit and the handoff; the power
// unit finishes sooner when the sample or the denominator is zero. Most of its
// work is sixteen log2 squarings, sixteen exp2 products and seventeen divide steps.
// The last channel of a vector flushes up to half+1 results one after another.
// Reset clears control state and loads the register defaults; the window RAM
// needs no clearing, as only channels of the current vector are ever read.
// A finished result waits in the output register under out_stall while the
// next one is already being computed; in_stall is high while any beat works.
module cross_channel_response_normalizer #(
	parameter int MAX_HALF_WINDOW = 7,
	parameter int MAX_CHANNELS    = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [1:0]                            cfg_index,
	input  logic [23:0]                           cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ccrn_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  last_channel,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ccrn_pkg::SAMPLE_W-1:0]  value,
	output logic                                  zero_divisor,
	output logic                                  saturated,
	output logic                                  last
);
	import ccrn_pkg::*;

	localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
	localparam int AW        = $clog2(WIN_DEPTH);
	localparam int CW        = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;
	localparam int IW        = ((AW > OFS_W) ? AW : OFS_W) + 1;

	typedef enum logic [2:0] {
		T_IDLE,
		T_START,
		T_RD,
		T_SQ,
		T_ACC,
		T_POW,
		T_OUT
	} state_t;

	state_t                     state_q;
	logic [15:0]                bias_k_q;
	logic [23:0]                scale_alpha_q;
	logic [15:0]                exponent_beta_q;
	logic [3:0]                 window_size_q;
	logic [CW-1:0]              cnt_q;
	logic [AW-1:0]              ptr_q;
	logic [CW-1:0]              chan_q;
	logic [AW-1:0]              cur_ptr_q;
	logic [HALF_W-1:0]          half_q;
	logic [HALF_W-1:0]          dj_q;
	logic                       flush_q;
	logic [OFS_W-1:0]           d_q;
	logic [SUM_W-1:0]           sum_q;
	logic [31:0]                sq_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       pow_start_q;
	logic                       out_valid_q;
	ccrn_result_t               out_res_q;
	logic                       out_last_q;

	logic                       accept;
	logic [HALF_W-1:0]          ws_half;
	logic [HALF_W-1:0]          half;
	logic                       is_last;
	logic [OFS_W-1:0]           dsum;
	logic [OFS_W-1:0]           dl;
	logic [IW-1:0]              diff;
	logic [AW-1:0]              rd_addr;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic signed [31:0]         sq_full;
	logic                       out_free;
	ccrn_cfg_t                  pow_cfg;
	logic                       pow_done;
	ccrn_result_t               pow_res;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != T_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign ws_half = window_size_q[3:1];
	assign half    = (32'(ws_half) > MAX_HALF_WINDOW) ? HALF_W'(MAX_HALF_WINDOW) : ws_half;
	assign is_last = last_channel || (cnt_q == CW'(MAX_CHANNELS - 1));

	// Lowest tap of the window is clipped at the vector start.
	assign dsum = OFS_W'(dj_q) + OFS_W'(half_q);
	assign dl   = (32'(dsum) > 32'(chan_q)) ? OFS_W'(chan_q) : dsum;

	// Tap at offset d behind the current channel, wrapped in the circular window.
	assign diff    = IW'(cur_ptr_q) - IW'(d_q);
	assign rd_addr = diff[IW-1] ? AW'(diff + IW'(WIN_DEPTH)) : AW'(diff);

	assign sq_full = rd_data * rd_data;

	assign pow_cfg = '{bias_k: bias_k_q, scale_alpha: scale_alpha_q,
		exponent_beta: exponent_beta_q};

	ccrn_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WIN_DEPTH)
	) u_window (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (ptr_q),
		.wr_data (sample),
		.rd_en   (state_q == T_RD),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ccrn_power u_power (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pow_start_q),
		.cfg    (pow_cfg),
		.sum    (sum_q),
		.x      (x_q),
		.done   (pow_done),
		.result (pow_res)
	);

	// Configuration registers; writes must arrive only while idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_k_q        <= BIAS_K_RST;
			scale_alpha_q   <= SCALE_ALPHA_RST;
			exponent_beta_q <= EXPONENT_BETA_RST;
			window_size_q   <= WINDOW_SIZE_RST;
		end else if (cfg_wr_en) begin
			case (ccrn_cfg_idx_t'(cfg_index))
				CFG_BIAS_K:        bias_k_q        <= cfg_wdata[15:0];
				CFG_SCALE_ALPHA:   scale_alpha_q   <= cfg_wdata;
				CFG_EXPONENT_BETA: exponent_beta_q <= cfg_wdata[15:0];
				CFG_WINDOW_SIZE:   window_size_q   <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			pow_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pow_start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						chan_q    <= cnt_q;
						cur_ptr_q <= ptr_q;
						half_q    <= half;
						if (is_last) begin
							// Flush every pending channel of the vector.
							cnt_q   <= '0;
							ptr_q   <= '0;
							flush_q <= 1'b1;
							dj_q    <= (32'(cnt_q) < 32'(half)) ? HALF_W'(cnt_q) : half;
							state_q <= T_START;
						end else begin
							cnt_q   <= cnt_q + CW'(1);
							ptr_q   <= (ptr_q == AW'(WIN_DEPTH - 1)) ? '0 : ptr_q + AW'(1);
							flush_q <= 1'b0;
							dj_q    <= half;
							if (32'(cnt_q) >= 32'(half)) begin
								state_q <= T_START;
							end
						end
					end
				end
				T_START: begin
					d_q     <= dl;
					sum_q   <= '0;
					state_q <= T_RD;
				end
				T_RD: begin
					state_q <= T_SQ;
				end
				T_SQ: begin
					sq_q <= sq_full;
					if (d_q == OFS_W'(dj_q)) begin
						x_q <= rd_data;
					end
					state_q <= T_ACC;
				end
				T_ACC: begin
					sum_q <= sum_q + SUM_W'(sq_q);
					if (d_q == '0) begin
						pow_start_q <= 1'b1;
						state_q     <= T_POW;
					end else begin
						d_q     <= d_q - OFS_W'(1);
						state_q <= T_RD;
					end
				end
				T_POW: begin
					if (pow_done) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_res_q   <= pow_res;
						out_last_q  <= flush_q && (dj_q == '0);
						if (flush_q && (dj_q != '0)) begin
							dj_q    <= dj_q - HALF_W'(1);
							state_q <= T_START;
						end else begin
							state_q <= T_IDLE;
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = out_res_q.value;
	assign zero_divisor = out_res_q.zero_divisor;
	assign saturated    = out_res_q.saturated;
	assign last         = out_last_q;

endmodule

>>> bench/cross_channel_response_normalizer_tb.sv
// Self-checking bench for the cross-channel response normalizer.
`timescale 1ns / 1ps

module cross_channel_response_normalizer_tb;
	import ccrn_pkg::*;

	localparam int  HALF_CAP   = 7;
	localparam int  WIN_DEPTH  = 2 * HALF_CAP + 1;
	localparam int  CHAN_LIMIT = 1024;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic signed [15:0] sample;
		bit                 last_channel;
	} chan_beat_t;

	typedef struct {
		logic signed [15:0] value;
		bit                 zero_divisor;
		bit                 saturated;
		bit                 last;
	} norm_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic signed [15:0] sample = '0;
	logic        last_channel = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic signed [15:0] value;
	logic        zero_divisor;
	logic        saturated;
	logic        last;

	cross_channel_response_normalizer dut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the block: registers, sample ring and channel counter.
	logic [15:0] k_q88;
	logic [23:0] alpha_q24;
	logic [15:0] beta_q14;
	logic [3:0]  win_n;
	logic [15:0] ring [WIN_DEPTH];
	int unsigned next_chan;
	longint unsigned pow2_frac_tbl [16];

	chan_beat_t pending_beats [$];
	norm_out_t  expected_outs [$];
	int         errors;
	int         outs_seen;
	bit         calm;
	longint     cycles;

	// Integer square root, two bits of the radicand per step.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint chan_sample(int unsigned ch);
		return longint'($signed(ring[ch % WIN_DEPTH]));
	endfunction

	// Normalize channel j of a vector whose newest channel is c.
	function automatic void normalize_channel(int unsigned j, int unsigned c,
			int unsigned half, bit is_last);
		int unsigned lo, hi;
		longint unsigned sq, base, m, mag;
		longint l16, e16, ip, t, x, v;
		int unsigned frac, f;
		int p;
		norm_out_t o;
		lo = (j >= half) ? j - half : 0;
		hi = (j + half < c) ? j + half : c;
		sq = 0;
		for (int unsigned h = lo; h <= hi; h++) begin
			v = chan_sample(h);
			sq += longint'(v * v);
		end
		base = (longint'(k_q88) << 32) + longint'(alpha_q24) * sq;
		x = chan_sample(j);
		o.zero_divisor = 0;
		o.saturated = 0;
		o.last = is_last;
		if (base == 0 && beta_q14 != 0) begin
			o.zero_divisor = 1;
			o.value = 0;
		end else begin
			l16 = 0;
			if (base != 0) begin
				frac = 0;
				p = 63;
				while (base[p] == 1'b0) p--;
				m = (p >= 30) ? base >> (p - 30) : base << (30 - p);
				for (int i = 0; i < 16; i++) begin
					m = (m * m) >> 30;
					frac <<= 1;
					if (m >= (64'd1 << 31)) begin
						frac |= 1;
						m >>= 1;
					end
				end
				l16 = longint'(p - 40) * 65536 + longint'(frac);
			end
			// Arithmetic shifts of signed values floor toward minus infinity.
			e16 = (longint'(beta_q14) * l16) >>> 14;
			ip = e16 >>> 16;
			f = int'(e16 - ip * 65536);
			m = 64'd1 << 30;
			for (int i = 0; i < 16; i++)
				if (f[15 - i]) m = (m * pow2_frac_tbl[i]) >> 30;
			mag = (x < 0) ? -x : x;
			t = 30 - ip;
			if (mag == 0) mag = 0;
			else if (t >= 47) mag = 64'd1 << 20;
			else if (t >= 0) mag = (mag << t) / m;
			else if (t <= -33) mag = 0;
			else mag = mag / (m << (-t));
			if (x < 0) begin
				if (mag > 32768) begin
					mag = 32768;
					o.saturated = 1;
				end
				o.value = -mag;
			end else begin
				if (mag > 32767) begin
					mag = 32767;
					o.saturated = 1;
				end
				o.value = mag;
			end
		end
		expected_outs.push_back(o);
	endfunction

	// Advance the shadow state by one accepted input beat.
	function automatic void take_channel(logic [15:0] s, bit mark);
		int unsigned c, half;
		bit ends;
		c = next_chan % CHAN_LIMIT;
		half = win_n >> 1;
		if (half > HALF_CAP) half = HALF_CAP;
		ends = mark || c == CHAN_LIMIT - 1;
		ring[c % WIN_DEPTH] = s;
		if (!ends) begin
			if (c >= half) normalize_channel(c - half, c, half, 0);
			next_chan = c + 1;
		end else begin
			for (int unsigned j = (c >= half) ? c - half : 0; j <= c; j++)
				normalize_channel(j, c, half, j == c);
			next_chan = 0;
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sender: hold a stalled beat, advance on acceptance, idle for a random gap between beats.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) take_channel(sample, last_channel);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					chan_beat_t b;
					b = pending_beats.pop_front();
					sample <= b.sample;
					last_channel <= b.last_channel;
					in_valid <= 1'b1;
					send_gap <= gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter: one long stretch once enough results have passed, so
	// the block fills up and stalls its input.
	int hold_left;
	bit held;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			held      <= 1'b0;
		end else if (!held && outs_seen >= 120) begin
			hold_left <= 400;
			held      <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: check each result beat against the oldest expectation and drive out_stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outs.size() == 0) begin
					$display("%0t: unexpected result value=%0d", $time, value);
					errors++;
				end else begin
					norm_out_t e;
					e = expected_outs.pop_front();
					if (value !== e.value || zero_divisor !== e.zero_divisor ||
							saturated !== e.saturated || last !== e.last) begin
						$display("%0t: mismatch exp value=%0d zdiv=%0b sat=%0b last=%0b",
							$time, e.value, e.zero_divisor, e.saturated, e.last);
						$display("%0t:          got value=%0d zdiv=%0b sat=%0b last=%0b",
							$time, value, zero_divisor, saturated, last);
						errors++;
					end
				end
				outs_seen++;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= (gap_len() != 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(ccrn_cfg_idx_t idx, logic [23:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_BIAS_K:        k_q88 = data[15:0];
			CFG_SCALE_ALPHA:   alpha_q24 = data;
			CFG_EXPONENT_BETA: beta_q14 = data[15:0];
			default:           win_n = data[3:0];
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_regs(logic [15:0] k, logic [23:0] a, logic [15:0] b, logic [3:0] n);
		write_reg(CFG_BIAS_K, 24'(k));
		write_reg(CFG_SCALE_ALPHA, a);
		write_reg(CFG_EXPONENT_BETA, 24'(b));
		write_reg(CFG_WINDOW_SIZE, 24'(n));
	endtask

	// Wait until every beat is in and every result is out, then let the power
	// unit settle before touching registers.
	task automatic drain();
		wait (pending_beats.size() == 0 && !in_valid && expected_outs.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic queue_beat(logic [15:0] s, bit mark);
		chan_beat_t b;
		b.sample = s;
		b.last_channel = mark;
		pending_beats.push_back(b);
	endtask

	function automatic logic [15:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 16'sh7fff;
		if (r < 10) return 16'sh8000;
		if (r < 15) return 0;
		if (r < 40) return $urandom_range(0, 1023) - 512;
		return $urandom;
	endfunction

	task automatic queue_vector(int len);
		for (int i = 0; i < len; i++) queue_beat(rand_sample(), i == len - 1);
	endtask

	function automatic logic [23:0] pick(int unsigned hi_val);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return hi_val;
		if (r < 5) return $urandom_range(0, 2048);
		return $urandom_range(0, hi_val);
	endfunction

	initial begin
		longint unsigned c2;
		int sent;
		k_q88 = BIAS_K_RST;
		alpha_q24 = SCALE_ALPHA_RST;
		beta_q14 = EXPONENT_BETA_RST;
		win_n = WINDOW_SIZE_RST;
		for (int i = 0; i < WIN_DEPTH; i++) ring[i] = 0;
		next_chan = 0;
		c2 = 64'd2 << 30;
		for (int i = 0; i < 16; i++) begin
			c2 = int_sqrt(c2 << 30);
			pow2_frac_tbl[i] = c2;
		end
		errors = 0;
		outs_seen = 0;
		cycles = 0;
		calm = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes under the reset settings.
		queue_beat(16'sh7fff, 0);
		queue_beat(16'sh8000, 0);
		queue_beat(0, 0);
		queue_beat(1, 0);
		queue_beat(16'shffff, 0);
		queue_beat(16'h5555, 0);
		queue_beat(16'haaaa, 1);
		queue_beat(16'sh0100, 1);  // single-channel vector
		drain();
		// Zero denominator with a positive exponent, widest window.
		set_regs(0, 0, 16'd16384, 4'd15);
		queue_beat(16'sh0200, 0);
		queue_beat(16'sh8000, 0);
		queue_beat(0, 1);
		drain();
		// Zero exponent: denominator is one, sample passes through.
		write_reg(CFG_EXPONENT_BETA, 0);
		queue_beat(16'sh1234, 0);
		queue_beat(16'sh8000, 1);
		drain();
		// Tiny bias with unit exponent saturates; window of one.
		set_regs(16'd1, 0, 16'd16384, 4'd1);
		queue_beat(16'sh4000, 0);
		queue_beat(16'shc000, 0);
		queue_beat(16'sh0001, 1);
		drain();
		// Every register at its maximum.
		set_regs(16'hffff, 24'hffffff, 16'hffff, 4'd15);
		queue_beat(16'sh7fff, 0);
		queue_beat(16'sh8000, 0);
		queue_beat(16'sh0080, 1);
		drain();

		// Random phases with fresh settings between them.
		sent = 0;
		while (sent < 320) begin
			set_regs(16'(pick(16'hffff)), pick(24'hffffff), 16'(pick(16'hffff)),
				4'($urandom_range(1, 15)));
			calm = ($urandom_range(0, 3) == 0);
			for (int v = 0; v < 4; v++) begin
				int len;
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
					: $urandom_range(4, 20);
				queue_vector(len);
				sent += len;
			end
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/ccrn_pkg.sv
rtl/ccrn_ram.sv
rtl/ccrn_power.sv
rtl/cross_channel_response_normalizer.sv
bench/cross_channel_response_normalizer_tb.sv
